>>> rtl/tmt_pkg.sv
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared widths and defaults for the trimmed-mean threshold detector.
// ----------------------------------------------------------------------------
package tmt_pkg;

    localparam int DATA_W      = 12;
    localparam int DEF_SAMPLES = 10;
    localparam int DEF_TRIM    = 2;

    localparam logic [DATA_W-1:0] THR_RESET = 12'd2400;

endpackage

>>> rtl/tmt_ram.sv
// ----------------------------------------------------------------------------
// tmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmt_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tmt_cmpsub.sv
// ----------------------------------------------------------------------------
// tmt_cmpsub
// Shared magnitude compare unit: the a >= b flag.
// ----------------------------------------------------------------------------
module tmt_cmpsub #(
    parameter int W = 18
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge
);

    assign o_ge = (i_a >= i_b);

endmodule

>>> rtl/trimmed_mean_threshold.sv
// A sample holds stall high from when it is taken: a read and a compare step for each
//   stored entry it is tested against (it moves past at most SAMPLES-1 of them), the
//   last compare or a read step at the bottom entry writing it in. The sample that closes
//   a batch then adds a read and an accumulate step for each kept entry, a divide step
//   and a threshold step, held while a word waits. The single RAM port pair and the
//   shared compare unit allow one sample per insertion. Stall is high while busy.
// Reset (synchronous, active low): fill count 0, threshold 2400, no result.
// ----------------------------------------------------------------------------
// trimmed_mean_threshold
// Batches samples in a sorted store, then emits the trimmed mean and alarm.
// ----------------------------------------------------------------------------
module trimmed_mean_threshold
    import tmt_pkg::*;
#(
    parameter int SAMPLES = DEF_SAMPLES,
    parameter int TRIM    = DEF_TRIM
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [DATA_W-1:0] i_sample,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_mean,
    output logic              o_above,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [DATA_W-1:0] i_cfg_data
);

    localparam int EFF_TRIM = (TRIM > (SAMPLES - 1) / 2) ? (SAMPLES - 1) / 2 : TRIM;
    localparam int KEPT     = SAMPLES - 2 * EFF_TRIM;
    localparam int IW       = $clog2(SAMPLES);
    localparam int SUM_W    = $clog2(SAMPLES * ((1 << DATA_W) - 1) + 1);
    localparam int DIV_SH   = SUM_W + $clog2(KEPT);
    localparam int RCP_W    = DIV_SH + 1;
    localparam int PROD_W   = SUM_W + RCP_W;

    localparam logic [IW-1:0]     LAST_CNT = IW'(SAMPLES - 1);
    localparam logic [IW-1:0]     FIRST_K  = IW'(EFF_TRIM);
    localparam logic [IW-1:0]     LAST_K   = IW'(SAMPLES - 1 - EFF_TRIM);
    localparam logic [SUM_W-1:0]  DIVISOR  = SUM_W'(KEPT);
    localparam logic [RCP_W-1:0]  RECIP    = RCP_W'(((1 << DIV_SH) + KEPT - 1) / KEPT);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_INS_RD  = 7'b0000010,
        S_INS_CMP = 7'b0000100,
        S_SUM_RD  = 7'b0001000,
        S_SUM_ACC = 7'b0010000,
        S_DIV     = 7'b0100000,
        S_THR     = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_hole, n_hole;
    logic [IW-1:0]       r_addr, n_addr;
    logic [DATA_W-1:0]   r_val, n_val;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SUM_W-1:0]    r_rem, n_rem;
    logic [DATA_W-1:0]   r_quo, n_quo;
    logic [DATA_W-1:0]   r_thr, n_thr;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_mean, n_out_mean;
    logic                r_out_above, n_out_above;

    logic                ins_done;
    logic                mem_we, mem_re;
    logic [IW-1:0]       mem_waddr, mem_raddr;
    logic [DATA_W-1:0]   mem_wdata, mem_rdata;
    logic [SUM_W-1:0]    alu_a, alu_b;
    logic                alu_ge;
    logic [SUM_W-1:0]    sum_next;
    logic [PROD_W-1:0]   div_prod;

    tmt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tmt_cmpsub #(
        .W (SUM_W)
    ) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_ge   (alu_ge)
    );

    assign sum_next    = r_sum + SUM_W'(mem_rdata);
    assign div_prod    = PROD_W'(r_rem) * PROD_W'(RECIP);
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_mean      = r_out_mean;
    assign o_above     = r_out_above;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_hole      = r_hole;
        n_addr      = r_addr;
        n_val       = r_val;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_thr       = r_thr;
        n_out_valid = r_out_valid;
        n_out_mean  = r_out_mean;
        n_out_above = r_out_above;
        ins_done    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_hole;
        mem_wdata   = r_val;
        mem_re      = 1'b0;
        mem_raddr   = r_hole - IW'(1);
        alu_a       = '0;
        alu_b       = '0;

        if (i_cfg_valid) begin
            n_thr = i_cfg_data;
        end

        // drop the result word once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val   = i_sample;
                    n_hole  = r_count;
                    n_state = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (r_hole == '0) begin
                    mem_we   = 1'b1;
                    ins_done = 1'b1;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                // new value >= stored entry: it lands in the hole
                alu_a  = SUM_W'(r_val);
                alu_b  = SUM_W'(mem_rdata);
                mem_we = 1'b1;
                if (alu_ge) begin
                    ins_done = 1'b1;
                end else begin
                    mem_wdata = mem_rdata;
                    n_hole    = r_hole - IW'(1);
                    n_state   = S_INS_RD;
                end
            end
            S_SUM_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_addr;
                n_state   = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                n_sum = sum_next;
                if (r_addr == LAST_K) begin
                    n_rem   = sum_next;
                    n_quo   = '0;
                    n_state = S_DIV;
                end else begin
                    n_addr  = r_addr + IW'(1);
                    n_state = S_SUM_RD;
                end
            end
            S_DIV: begin
                // scale by the rounded-up reciprocal of the kept count, keep the integer part
                n_quo   = div_prod[DIV_SH +: DATA_W];
                n_state = S_THR;
            end
            S_THR: begin
                // mean > threshold  <=>  not (threshold >= mean)
                alu_a = SUM_W'(r_thr);
                alu_b = SUM_W'(r_quo);
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_mean  = r_quo;
                    n_out_above = ~alu_ge;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ins_done) begin
            if (r_count == LAST_CNT) begin
                n_count = '0;
                n_addr  = FIRST_K;
                n_sum   = '0;
                n_state = S_SUM_RD;
            end else begin
                n_count = r_count + IW'(1);
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_thr       <= n_thr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole      <= n_hole;
        r_addr      <= n_addr;
        r_val       <= n_val;
        r_sum       <= n_sum;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_out_mean  <= n_out_mean;
        r_out_above <= n_out_above;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_CNT)
        else $error("fill count beyond batch size");

    a_accept_starts_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_INS_RD))
        else $error("accepted word did not start an insertion");

    a_result_from_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_THR))
        else $error("result word loaded outside the threshold step");

    a_div_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_THR) |-> ((SUM_W'(r_quo) * DIVISOR <= r_rem) &&
                                (r_rem - SUM_W'(r_quo) * DIVISOR < DIVISOR)))
        else $error("quotient is not the truncated mean");

    a_div_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_THR))
        else $error("divide step did not advance to the threshold step");

endmodule
